// ===== hdl/bbm_pkg.sv =====
// Shared types, constants and helpers for the banked bus memory.
`default_nettype none

package bbm_pkg;

  // Geometry
  localparam int ADDR_BITS      = 18;
  localparam int BLOCK_SHIFT    = 12;
  localparam int WORD_ADDR_BITS = ADDR_BITS - 1;
  localparam int WORD_COUNT     = 1 << WORD_ADDR_BITS;
  localparam int BLOCK_BITS     = ADDR_BITS - BLOCK_SHIFT;
  localparam int MASK_BITS      = 62;
  localparam int MASK_HI_BITS   = MASK_BITS - 32;

  localparam logic [31:0] ID_VALUE        = 32'h424D_2005;
  localparam logic [31:0] BAD_INDEX_VALUE = 32'hDEAD_BEEF;

  // Input commands
  typedef enum logic [2:0] {
    CMD_REG_RD  = 3'd0,
    CMD_REG_WR  = 3'd1,
    CMD_BUS_RD  = 3'd2,
    CMD_WORD_WR = 3'd3,
    CMD_BYTE_WR = 3'd4
  } cmd_e;

  // Register indexes
  localparam logic [3:0] REG_ID      = 4'd0;
  localparam logic [3:0] REG_MASK_LO = 4'd1;
  localparam logic [3:0] REG_MASK_HI = 4'd2;
  localparam logic [3:0] REG_ADDR    = 4'd3;
  localparam logic [3:0] REG_DATA    = 4'd4;

  // Actions carried in bits 31..29 of an address register write
  localparam logic [2:0] ACT_LO_BYTE = 3'd1;
  localparam logic [2:0] ACT_HI_BYTE = 3'd2;
  localparam logic [2:0] ACT_WORD    = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // One access to the word store
  typedef struct packed {
    logic                      en;
    logic                      we;
    logic [1:0]                be;
    logic [WORD_ADDR_BITS-1:0] addr;
    logic [15:0]               wdata;
  } mem_req_t;

  // Decoded outcome of the item being accepted
  typedef struct packed {
    logic        mem_rd;     // result waits for the store's read data
    logic        to_staged;  // read data goes to staged data, not the bus
    logic        ack;
    logic [31:0] reg_rdata;
  } dec_t;

  // Block reachable from the bus: only the block's own enable bit counts
  function automatic logic blk_enabled(input logic [MASK_BITS-1:0] mask,
                                       input logic [ADDR_BITS-1:0] addr);
    logic [BLOCK_BITS-1:0] blk;
    logic                  hit;
    blk = addr[ADDR_BITS-1:BLOCK_SHIFT];
    hit = 1'b0;
    for (int i = 0; i < MASK_BITS; i++) begin
      if (32'(blk) == i) hit = mask[i];
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bbm_ram.sv =====
// Single-port word store with byte-lane write enables and registered read.
`default_nettype none

module bbm_ram (
  input  wire logic              clk,
  input  wire bbm_pkg::mem_req_t req,
  output logic [15:0]            rdata
);
  import bbm_pkg::*;

  logic [15:0] mem [WORD_COUNT];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        if (req.be[0]) mem[req.addr][7:0]  <= req.wdata[7:0];
        if (req.be[1]) mem[req.addr][15:8] <= req.wdata[15:8];
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bbm_hostregs.sv =====
// Host registers, command decode and memory request generation.
`default_nettype none

module bbm_hostregs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [2:0]        command,
  input  wire logic [3:0]        reg_index,
  input  wire logic [31:0]       write_data,
  input  wire logic [17:0]       bus_addr,
  input  wire logic              load_staged,
  input  wire logic [15:0]       mem_rdata,
  output bbm_pkg::mem_req_t      mem_req,
  output bbm_pkg::dec_t          dec
);
  import bbm_pkg::*;

  logic [MASK_BITS-1:0] mask_r, mask_nxt;
  logic [ADDR_BITS-1:0] staged_addr_r, staged_addr_nxt;
  logic [15:0]          staged_data_r, staged_data_nxt;

  logic [ADDR_BITS-1:0] baddr;
  logic [ADDR_BITS-1:0] new_addr;
  logic [2:0]           action;
  logic                 enabled;

  assign baddr    = ADDR_BITS'(bus_addr);
  assign new_addr = ADDR_BITS'(write_data) & ~ADDR_BITS'(1);
  assign action   = write_data[31:29];
  assign enabled  = blk_enabled(mask_r, baddr);

  always_comb begin
    mask_nxt        = mask_r;
    staged_addr_nxt = staged_addr_r;
    staged_data_nxt = staged_data_r;
    mem_req         = '0;
    mem_req.addr    = baddr[ADDR_BITS-1:1];
    dec             = '0;

    unique case (command)
      CMD_REG_RD: begin
        unique case (reg_index)
          REG_ID:      dec.reg_rdata = ID_VALUE;
          REG_MASK_LO: dec.reg_rdata = mask_r[31:0];
          REG_MASK_HI: dec.reg_rdata = 32'(mask_r[MASK_BITS-1:32]);
          REG_ADDR:    dec.reg_rdata = 32'(staged_addr_r);
          REG_DATA:    dec.reg_rdata = 32'(staged_data_r);
          default:     dec.reg_rdata = BAD_INDEX_VALUE;
        endcase
      end
      CMD_REG_WR: begin
        unique case (reg_index)
          REG_MASK_LO: mask_nxt[31:0] = write_data;
          REG_MASK_HI: mask_nxt[MASK_BITS-1:32] = write_data[MASK_HI_BITS-1:0];
          REG_ADDR: begin
            staged_addr_nxt = new_addr;
            mem_req.addr    = new_addr[ADDR_BITS-1:1];
            mem_req.wdata   = staged_data_r;
            unique case (action)
              ACT_LO_BYTE: begin
                mem_req.en = 1'b1; mem_req.we = 1'b1; mem_req.be = 2'b01;
              end
              ACT_HI_BYTE: begin
                mem_req.en = 1'b1; mem_req.we = 1'b1; mem_req.be = 2'b10;
              end
              ACT_WORD: begin
                mem_req.en = 1'b1; mem_req.we = 1'b1; mem_req.be = 2'b11;
              end
              ACT_READ: begin
                mem_req.en    = 1'b1;
                dec.mem_rd    = 1'b1;
                dec.to_staged = 1'b1;
              end
              default: ;
            endcase
          end
          REG_DATA: staged_data_nxt = write_data[15:0];
          default: ;
        endcase
      end
      CMD_BUS_RD: begin
        if (enabled) begin
          mem_req.en = 1'b1;
          dec.mem_rd = 1'b1;
          dec.ack    = 1'b1;
        end
      end
      CMD_WORD_WR: begin
        if (enabled) begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.be    = 2'b11;
          mem_req.wdata = write_data[15:0];
          dec.ack       = 1'b1;
        end
      end
      CMD_BYTE_WR: begin
        if (enabled) begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.be    = baddr[0] ? 2'b10 : 2'b01;
          mem_req.wdata = {write_data[7:0], write_data[7:0]};
          dec.ack       = 1'b1;
        end
      end
      default: ;
    endcase

    // hold everything unless the item is taken now
    if (!accept) begin
      mask_nxt        = mask_r;
      staged_addr_nxt = staged_addr_r;
      staged_data_nxt = staged_data_r;
      mem_req.en      = 1'b0;
    end
    if (load_staged) staged_data_nxt = mem_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r        <= '0;
      staged_addr_r <= '0;
      staged_data_r <= '0;
    end else begin
      mask_r        <= mask_nxt;
      staged_addr_r <= staged_addr_nxt;
      staged_data_r <= staged_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/banked_bus_memory_with_reg_port_unit.sv =====
// Top level of the banked bus memory with host register port.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: a register
//   read or write, a bus read, a bus word write or a bus byte write. Every
//   input beat produces exactly one result beat on the output channel
//   (out_valid/out_ready) with the register read value, the bus acknowledge
//   and the bus read word; fields that do not apply are zero.
//   Flow: register accesses, writes and refused bus accesses have their
//   result registered at the accept edge, one beat per cycle while the
//   receiver takes results. A bus read and an address register write with
//   the read action pass through the read wait state, since the single-port
//   word store has a registered read; the input is held off in that state.
//   The output register frees the input side: a new beat is taken in the
//   same cycle the pending result leaves. While the receiver stalls with a
//   result waiting, in_ready stays low and all state holds.
//   Reset (rst_n low, synchronous) clears the enable mask, staged address,
//   staged data and the handshake state. The word store is not cleared:
//   words never written read back undefined.
`default_nettype none

module banked_bus_memory_with_reg_port_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [3:0]  in_reg_index,
  input  wire logic [31:0] in_write_data,
  input  wire logic [17:0] in_bus_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_reg_read_data,
  output logic             out_bus_ack,
  output logic [15:0]      out_bus_read_data
);
  import bbm_pkg::*;

  state_t      state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] reg_rdata_r;
  logic        ack_r;
  logic [15:0] bus_rdata_r;
  logic        pend_staged_r;

  logic        accept;
  logic        load_out;
  logic        load_staged;
  mem_req_t    mem_req;
  dec_t        dec;
  logic [15:0] mem_rdata;

  assign accept = in_valid && in_ready;

  bbm_hostregs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_command),
    .reg_index   (in_reg_index),
    .write_data  (in_write_data),
    .bus_addr    (in_bus_addr),
    .load_staged (load_staged),
    .mem_rdata   (mem_rdata),
    .mem_req     (mem_req),
    .dec         (dec)
  );

  bbm_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Next state: a read parks in the wait state for the store's data
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && dec.mem_rd) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    load_out    = 1'b0;
    load_staged = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // take a beat when the result slot is empty or draining now
        in_ready = !out_valid_r || out_ready;
        load_out = accept && !dec.mem_rd;
      end
      ST_READ: begin
        load_out    = 1'b1;
        load_staged = pend_staged_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) pend_staged_r <= dec.to_staged;
    if (load_out) begin
      if (state_r == ST_READ) begin
        reg_rdata_r <= '0;
        ack_r       <= !pend_staged_r;
        bus_rdata_r <= pend_staged_r ? 16'h0000 : mem_rdata;
      end else begin
        reg_rdata_r <= dec.reg_rdata;
        ack_r       <= dec.ack;
        bus_rdata_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reg_read_data = reg_rdata_r;
  assign out_bus_ack       = ack_r;
  assign out_bus_read_data = bus_rdata_r;

  // The result slot is always free while read data is awaited
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !out_valid_r)
    else $error("result slot busy during store read");

  // An accepted read moves to the wait state
  a_read_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    accept && dec.mem_rd |=> state_r == ST_READ)
    else $error("store read did not enter wait state");

  // The wait state returns to idle in the following cycle and leaves a result behind
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_IDLE && out_valid_r)
    else $error("store read result not delivered");

  // Bus read data only accompanies an acknowledge
  a_rdata_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bus_read_data != 16'h0000 |-> out_bus_ack)
    else $error("bus read data without acknowledge");

  // Memory is never touched without an accepted beat
  a_mem_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.en |-> accept)
    else $error("store access without accepted beat");

endmodule

`default_nettype wire

// ===== bench/bbm_tb_pkg.sv =====
// Beat types and the shadow model used to predict replies of the banked bus memory.
`timescale 1ns / 100ps

package bbm_tb_pkg;
  import bbm_pkg::*;

  typedef struct packed {
    logic [2:0]           command;
    logic [3:0]           reg_index;
    logic [31:0]          write_data;
    logic [ADDR_BITS-1:0] bus_addr;
  } beat_t;

  typedef struct packed {
    logic [31:0] reg_rdata;
    logic        ack;
    logic [15:0] bus_rdata;
  } reply_t;

  class bus_mem_shadow;
    logic [MASK_BITS-1:0] enable_mask;
    logic [ADDR_BITS-1:0] staged_addr;
    logic [15:0]          staged_word;
    logic [15:0]          words [WORD_COUNT];
    bit   [1:0]           filled [WORD_COUNT];  // byte lanes written so far
    reply_t               pending_replies [$];
    int                   errors;

    function new();
      enable_mask = '0;
      staged_addr = '0;
      staged_word = '0;
      errors      = 0;
    endfunction

    function bit reachable(logic [ADDR_BITS-1:0] a);
      int unsigned blk;
      blk = a >> BLOCK_SHIFT;
      return blk < MASK_BITS && enable_mask[blk] === 1'b1;
    endfunction

    function bit word_full(logic [ADDR_BITS-1:0] a);
      return filled[a[ADDR_BITS-1:1]] == 2'b11;
    endfunction

    function void put_byte(logic [ADDR_BITS-1:0] a, logic [7:0] v);
      logic [15:0] w;
      w = words[a[ADDR_BITS-1:1]];
      if (a[0]) w[15:8] = v;
      else w[7:0] = v;
      words[a[ADDR_BITS-1:1]] = w;
      filled[a[ADDR_BITS-1:1]][a[0]] = 1'b1;
    endfunction

    function void put_word(logic [ADDR_BITS-1:0] a, logic [15:0] v);
      words[a[ADDR_BITS-1:1]]  = v;
      filled[a[ADDR_BITS-1:1]] = 2'b11;
    endfunction

    function logic [31:0] reg_value(logic [3:0] idx);
      case (idx)
        REG_ID:      return ID_VALUE;
        REG_MASK_LO: return enable_mask[31:0];
        REG_MASK_HI: return 32'(enable_mask[MASK_BITS-1:32]);
        REG_ADDR:    return 32'(staged_addr);
        REG_DATA:    return 32'(staged_word);
        default:     return BAD_INDEX_VALUE;
      endcase
    endfunction

    function void reg_update(logic [3:0] idx, logic [31:0] v);
      case (idx)
        REG_MASK_LO: enable_mask[31:0] = v;
        REG_MASK_HI: enable_mask[MASK_BITS-1:32] = v[MASK_HI_BITS-1:0];
        REG_ADDR: begin
          staged_addr = {v[ADDR_BITS-1:1], 1'b0};
          case (v[31:29])
            ACT_LO_BYTE: put_byte(staged_addr, staged_word[7:0]);
            ACT_HI_BYTE: put_byte({staged_addr[ADDR_BITS-1:1], 1'b1}, staged_word[15:8]);
            ACT_WORD:    put_word(staged_addr, staged_word);
            ACT_READ:    staged_word = words[staged_addr[ADDR_BITS-1:1]];
            default: ;
          endcase
        end
        REG_DATA: staged_word = v[15:0];
        default: ;
      endcase
    endfunction

    // Advance the shadow by one accepted command beat and queue its reply.
    function void take_command(beat_t b);
      reply_t r;
      r = '0;
      case (b.command)
        CMD_REG_RD: r.reg_rdata = reg_value(b.reg_index);
        CMD_REG_WR: reg_update(b.reg_index, b.write_data);
        CMD_BUS_RD: if (reachable(b.bus_addr)) begin
          r.ack       = 1'b1;
          r.bus_rdata = words[b.bus_addr[ADDR_BITS-1:1]];
        end
        CMD_WORD_WR: if (reachable(b.bus_addr)) begin
          r.ack = 1'b1;
          put_word(b.bus_addr, b.write_data[15:0]);
        end
        CMD_BYTE_WR: if (reachable(b.bus_addr)) begin
          r.ack = 1'b1;
          put_byte(b.bus_addr, b.write_data[7:0]);
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: reply beat with none expected: rd=%h ack=%b bd=%h",
                 $time, got.reg_rdata, got.ack, got.bus_rdata);
        return;
      end
      want = pending_replies.pop_front();
      if (got.reg_rdata !== want.reg_rdata) begin
        errors++;
        $display("%0t: reg_read_data expected %h actual %h",
                 $time, want.reg_rdata, got.reg_rdata);
      end
      if (got.ack !== want.ack) begin
        errors++;
        $display("%0t: bus_ack expected %b actual %b", $time, want.ack, got.ack);
      end
      if (got.bus_rdata !== want.bus_rdata) begin
        errors++;
        $display("%0t: bus_read_data expected %h actual %h",
                 $time, want.bus_rdata, got.bus_rdata);
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
// Top-level testbench: drives command beats into the banked bus memory and checks every reply.
`timescale 1ns / 100ps

module tb;
  import bbm_pkg::*;
  import bbm_tb_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 9;
  localparam int PHASE_ITEMS  = 400;
  localparam int STALL_LIMIT  = 5000;  // cycles with no beat moving on either side
  localparam int TAIL_CYCLES  = 16;
  localparam int POOL_SIZE    = 32;
  localparam int CMD_CODES    = 8;
  localparam int REG_CODES    = 16;
  localparam logic [2:0] ACT_NONE = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_command;
  logic [3:0]  in_reg_index;
  logic [31:0] in_write_data;
  logic [17:0] in_bus_addr;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_reg_read_data;
  logic        out_bus_ack;
  logic [15:0] out_bus_read_data;

  bus_mem_shadow        shadow;
  logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];  // hot addresses so reads find written words
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   stall_cycles;

  banked_bus_memory_with_reg_port_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_reg_index      (in_reg_index),
    .in_write_data     (in_write_data),
    .in_bus_addr       (in_bus_addr),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reg_read_data (out_reg_read_data),
    .out_bus_ack       (out_bus_ack),
    .out_bus_read_data (out_bus_read_data)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: check the reply beat taken at this edge, then draw the stall
  // for the next cycle. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      shadow.check_reply(reply_t'({out_reg_read_data, out_bus_ack, out_bus_read_data}));
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly hot addresses, flipping the byte lane at random; the rest
  // anywhere in the space.
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    if ($urandom_range(99) < 85)
      return addr_pool[$urandom_range(POOL_SIZE - 1)] ^ ADDR_BITS'($urandom_range(1));
    return ADDR_BITS'($urandom);
  endfunction

  // Mask values lean toward many open blocks so bus traffic gets through.
  function automatic logic [31:0] mask_value();
    case ($urandom_range(5))
      0:       return '1;
      1:       return '0;
      2, 3:    return $urandom | $urandom;
      4:       return ~(32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int    pick;
    b.command    = CMD_REG_RD;
    b.reg_index  = 4'($urandom);
    b.write_data = $urandom;
    b.bus_addr   = pick_addr();
    pick = $urandom_range(99);
    if (pick < 8) begin
      if ($urandom_range(3) != 0) b.reg_index = 4'($urandom_range(REG_DATA));
    end else if (pick < 33) begin
      b.command = CMD_REG_WR;
      case ($urandom_range(9))
        0, 1: begin
          b.reg_index  = REG_MASK_LO;
          b.write_data = mask_value();
        end
        2: begin
          b.reg_index  = REG_MASK_HI;
          b.write_data = mask_value();
        end
        3, 4, 5: begin
          b.reg_index  = REG_ADDR;
          b.write_data = {3'($urandom), 11'($urandom), pick_addr()};
        end
        6, 7:    b.reg_index = REG_DATA;
        8:       b.reg_index = REG_ID;
        default: b.reg_index = 4'($urandom_range(REG_DATA + 1, REG_CODES - 1));
      endcase
    end else if (pick < 58) begin
      b.command = CMD_BUS_RD;
    end else if (pick < 78) begin
      b.command = CMD_WORD_WR;
    end else if (pick < 97) begin
      b.command = CMD_BYTE_WR;
    end else begin
      b.command = 3'($urandom_range(CMD_BYTE_WR + 1, CMD_CODES - 1));
    end
    return b;
  endfunction

  // Never let a read touch a word whose lanes are not both written.
  function automatic bit reads_written_only(beat_t b);
    if (b.command == CMD_BUS_RD)
      return shadow.word_full(b.bus_addr);
    if (b.command == CMD_REG_WR && b.reg_index == REG_ADDR && b.write_data[31:29] == ACT_READ)
      return shadow.word_full(b.write_data[ADDR_BITS-1:0]);
    return 1'b1;
  endfunction

  // Draw until the beat is safe to issue; fall back to a word write.
  function automatic beat_t next_beat();
    beat_t b;
    int    tries;
    tries = 0;
    do begin
      b = random_beat();
      tries++;
    end while (!reads_written_only(b) && tries < 20);
    if (!reads_written_only(b)) begin
      b.command  = CMD_WORD_WR;
      b.bus_addr = pick_addr();
    end
    return b;
  endfunction

  // Present one beat, hold it until taken, then note it in the shadow.
  // Valid drops only when an idle gap is drawn, so it is never lowered and
  // raised within one step.
  task automatic send_beat(input beat_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_command    <= b.command;
    in_reg_index  <= b.reg_index;
    in_write_data <= b.write_data;
    in_bus_addr   <= b.bus_addr;
    do @(posedge clk); while (!in_ready);
    shadow.take_command(b);
  endtask

  task automatic send_fields(input logic [2:0] c, input logic [3:0] idx,
                             input logic [31:0] d, input logic [ADDR_BITS-1:0] a);
    beat_t b;
    b = '{command: c, reg_index: idx, write_data: d, bus_addr: a};
    send_beat(b);
  endtask

  // Hold the sender off until every expected reply has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  initial begin
    beat_t b;
    int    blk;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = '0;
    in_reg_index  = '0;
    in_write_data = '0;
    in_bus_addr   = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shadow = new();

    // Hot addresses: low blocks, around the mask word split, the top blocks
    // (with and without enable bits) and anywhere.
    foreach (addr_pool[i]) begin
      case ($urandom_range(3))
        0:       blk = $urandom_range(2);
        1:       blk = $urandom_range(30, 33);
        2:       blk = $urandom_range(MASK_BITS - 2, MASK_BITS + 1);
        default: blk = $urandom_range(MASK_BITS + 1);
      endcase
      addr_pool[i] = {BLOCK_BITS'(blk), BLOCK_SHIFT'($urandom)};
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ID and unknown register, register-port access to memory,
    // refusals with an empty mask and in blocks without an enable bit,
    // odd word addresses, both byte lanes, every address action.
    send_fields(CMD_REG_RD, REG_ID, '0, '0);
    send_fields(CMD_REG_RD, 4'(REG_CODES - 1), '1, '1);
    send_fields(CMD_REG_WR, REG_DATA, 32'hFFFF_BEEF, '0);
    send_fields(CMD_REG_WR, REG_ADDR, {ACT_WORD, 11'h7FF, 18'h00001}, '0);
    send_fields(CMD_BUS_RD, REG_ID, '0, 18'h00000);
    send_fields(CMD_WORD_WR, REG_ID, '1, 18'h00001);
    send_fields(CMD_REG_WR, REG_MASK_LO, '1, '0);
    send_fields(CMD_REG_WR, REG_MASK_HI, '1, '1);
    send_fields(CMD_REG_RD, REG_MASK_HI, '0, '0);
    send_fields(CMD_WORD_WR, REG_ID, 32'h1234_A5C3, 18'h3DFFF);
    send_fields(CMD_BYTE_WR, REG_ID, 32'hFFFF_FF7E, 18'h3DFFF);
    send_fields(CMD_BYTE_WR, REG_ID, 32'h0000_0080, 18'h3DFFE);
    send_fields(CMD_BUS_RD, REG_ID, '0, 18'h3DFFF);
    send_fields(CMD_REG_WR, REG_ADDR, {ACT_WORD, 11'h000, 18'h3FFFF}, '0);
    send_fields(CMD_WORD_WR, REG_ID, 32'h0000_5A5A, 18'h3FFFF);
    send_fields(CMD_BUS_RD, REG_ID, '0, 18'h3FFFE);
    send_fields(CMD_REG_WR, REG_DATA, 32'h0000_1234, '0);
    send_fields(CMD_REG_WR, REG_ADDR, {ACT_LO_BYTE, 11'h000, 18'h00100}, '0);
    send_fields(CMD_REG_WR, REG_ADDR, {ACT_HI_BYTE, 11'h000, 18'h00101}, '0);
    send_fields(CMD_REG_WR, REG_ADDR, {ACT_READ, 11'h7FF, 18'h3FFFE}, '0);
    send_fields(CMD_REG_RD, REG_ADDR, '0, '0);
    send_fields(CMD_REG_RD, REG_DATA, '0, '0);
    send_fields(CMD_BUS_RD, REG_ID, '0, 18'h00101);
    send_fields(CMD_REG_WR, 4'(REG_CODES - 1), '1, '1);
    send_fields(CMD_REG_WR, REG_ID, '1, '0);
    send_fields(CMD_REG_WR, REG_ADDR, {~ACT_NONE, 29'h1FFF_FFFF}, '0);
    send_fields(CMD_REG_WR, REG_ADDR, {ACT_NONE, 29'h0000_0101}, '0);
    send_fields(3'(CMD_CODES - 1), '1, '1, '1);
    drain();

    // Random traffic in three phases of idling; drain between phases.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        b = next_beat();
        send_beat(b);
      end
      drain();
    end

    // Let any stray reply show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
